/* rtl/sli_pkg.sv */
// ----------------------------------------------------------------------------
// sli_pkg
// Shared widths, codes and controller/datapath link types for the sorted list.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int ST_W     = 3;
    localparam int EI_W     = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_DUMP   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_NEG    = 3'd3,
        ST_ABSENT = 3'd4
    } t_status;

    typedef struct packed {
        logic    accept;
        logic    j_from_cnt;
        logic    j_dec;
        logic    j_inc;
        logic    wr_en;
        logic    wr_val;
        logic    wr_jm1;
        logic    rd_jm1;
        logic    mark;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    out_load;
        logic    out_data;
        t_status out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic full;
        logic in_neg;
        logic j_zero;
        logic j_last;
        logic gt;
        logic eq;
        logic found;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/sli_req_if.sv */
// ----------------------------------------------------------------------------
// sli_req_if
// Command channel: one beat carries a command and its value.
// ----------------------------------------------------------------------------
interface sli_req_if;
    logic                                valid;
    logic                                ready;
    logic [sli_pkg::CMD_W-1:0]           cmd;
    logic signed [sli_pkg::DATA_W-1:0]   value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

/* rtl/sli_rsp_if.sv */
// ----------------------------------------------------------------------------
// sli_rsp_if
// Result channel: one beat per result item.
// ----------------------------------------------------------------------------
interface sli_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [sli_pkg::ST_W-1:0]            status;
    logic [sli_pkg::EI_W-1:0]            entry_index;
    logic signed [sli_pkg::DATA_W-1:0]   entry_value;
    logic                                last;

    modport source (output valid, output status, output entry_index,
                    output entry_value, output last, input ready);
    modport sink   (input valid, input status, input entry_index,
                    input entry_value, input last, output ready);
endinterface

/* rtl/sli_datapath.sv */
// ----------------------------------------------------------------------------
// sli_datapath
// Entry memory, count, scan index and the result output register.
// ----------------------------------------------------------------------------
module sli_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [sli_pkg::DATA_W-1:0] i_in_value,
    input  sli_pkg::t_dp_cmd                  i_cmd,
    output sli_pkg::t_dp_status               o_st,
    sli_rsp_if.source                         o_rsp
);

    logic signed [sli_pkg::DATA_W-1:0] r_mem [sli_pkg::CAPACITY];
    logic signed [sli_pkg::DATA_W-1:0] r_rd_data;
    logic signed [sli_pkg::DATA_W-1:0] r_value;
    logic [sli_pkg::CNT_W-1:0]         r_count;
    logic [sli_pkg::CNT_W-1:0]         r_j;
    logic [sli_pkg::IDX_W-1:0]         r_pos;
    logic                              r_found;

    logic                              r_out_valid;
    logic [sli_pkg::ST_W-1:0]          r_out_status;
    logic [sli_pkg::EI_W-1:0]          r_out_index;
    logic signed [sli_pkg::DATA_W-1:0] r_out_value;
    logic                              r_out_last;

    logic [sli_pkg::CNT_W-1:0]         jm1;
    logic [sli_pkg::IDX_W-1:0]         rd_addr;
    logic [sli_pkg::IDX_W-1:0]         wr_addr;
    logic signed [sli_pkg::DATA_W-1:0] wr_data;
    logic                              j_last;

    assign jm1     = r_j - sli_pkg::CNT_W'(1);
    assign rd_addr = i_cmd.rd_jm1 ? jm1[sli_pkg::IDX_W-1:0] : r_j[sli_pkg::IDX_W-1:0];
    assign wr_addr = i_cmd.wr_jm1 ? jm1[sli_pkg::IDX_W-1:0] : r_j[sli_pkg::IDX_W-1:0];
    assign wr_data = i_cmd.wr_val ? r_value : r_rd_data;
    assign j_last  = (r_j + sli_pkg::CNT_W'(1)) == r_count;

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_value <= i_in_value;
        end
        if (i_cmd.mark) begin
            r_pos <= r_j[sli_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_j     <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + sli_pkg::CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - sli_pkg::CNT_W'(1);
            end
            if (i_cmd.j_from_cnt) begin
                r_j <= r_count;
            end else if (i_cmd.accept) begin
                r_j <= '0;
            end else if (i_cmd.j_dec) begin
                r_j <= jm1;
            end else if (i_cmd.j_inc) begin
                r_j <= r_j + sli_pkg::CNT_W'(1);
            end
            if (i_cmd.accept) begin
                r_found <= 1'b0;
            end else if (i_cmd.mark) begin
                r_found <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            if (i_cmd.out_status != sli_pkg::ST_OK) begin
                r_out_index <= '0;
                r_out_value <= '0;
                r_out_last  <= 1'b1;
            end else if (i_cmd.out_data) begin
                r_out_index <= sli_pkg::EI_W'(r_j[sli_pkg::IDX_W-1:0]);
                r_out_value <= r_rd_data;
                r_out_last  <= j_last;
            end else begin
                r_out_index <= sli_pkg::EI_W'(r_pos);
                r_out_value <= r_value;
                r_out_last  <= 1'b1;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_index = r_out_index;
    assign o_rsp.entry_value = r_out_value;
    assign o_rsp.last        = r_out_last;

    always_comb begin
        o_st.cnt_zero = r_count == '0;
        o_st.full     = r_count == sli_pkg::CNT_W'(sli_pkg::CAPACITY);
        o_st.in_neg   = i_in_value[sli_pkg::DATA_W-1];
        o_st.j_zero   = r_j == '0;
        o_st.j_last   = j_last;
        o_st.gt       = r_rd_data > r_value;
        o_st.eq       = r_rd_data == r_value;
        o_st.found    = r_found;
        o_st.out_free = !r_out_valid || o_rsp.ready;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sli_pkg::CNT_W'(sli_pkg::CAPACITY))
        else $error("count above capacity");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> o_st.out_free)
        else $error("result register overwritten");

    a_no_inc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> !o_st.full && !i_cmd.cnt_dec)
        else $error("insert into full list");

    a_dec_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> !o_st.cnt_zero && (r_found || i_cmd.mark))
        else $error("remove without match");
`endif

endmodule

/* rtl/sli_ctrl.sv */
// ----------------------------------------------------------------------------
// sli_ctrl
// Command sequencer: insert scans down, remove scans up, dump walks entries.
// ----------------------------------------------------------------------------
module sli_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [sli_pkg::CMD_W-1:0] i_in_cmd,
    input  sli_pkg::t_dp_status       i_st,
    output logic                      o_in_ready,
    output sli_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_INS_RD  = 8'b0000_0010,
        S_INS_CHK = 8'b0000_0100,
        S_RM_RD   = 8'b0000_1000,
        S_RM_CHK  = 8'b0001_0000,
        S_DUMP_RD = 8'b0010_0000,
        S_DUMP_OUT= 8'b0100_0000,
        S_RESP    = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    sli_pkg::t_status r_rsp, n_rsp;
    logic             found_now;

    assign found_now = i_st.found || i_st.eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rsp   <= sli_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_rsp   <= n_rsp;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_rsp      = r_rsp;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (sli_pkg::t_cmd'(i_in_cmd))
                        sli_pkg::CMD_INSERT: begin
                            o_cmd.accept = 1'b1;
                            if (i_st.full) begin
                                n_rsp   = sli_pkg::ST_FULL;
                                n_state = S_RESP;
                            end else begin
                                o_cmd.j_from_cnt = 1'b1;
                                n_state          = S_INS_RD;
                            end
                        end
                        sli_pkg::CMD_REMOVE: begin
                            o_cmd.accept = 1'b1;
                            if (i_st.cnt_zero) begin
                                n_rsp   = sli_pkg::ST_EMPTY;
                                n_state = S_RESP;
                            end else if (i_st.in_neg) begin
                                n_rsp   = sli_pkg::ST_NEG;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_RM_RD;
                            end
                        end
                        sli_pkg::CMD_DUMP: begin
                            o_cmd.accept = 1'b1;
                            if (i_st.cnt_zero) begin
                                n_rsp   = sli_pkg::ST_EMPTY;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_DUMP_RD;
                            end
                        end
                        sli_pkg::CMD_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (i_st.j_zero) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_val  = 1'b1;
                    o_cmd.mark    = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_rsp         = sli_pkg::ST_OK;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.rd_jm1 = 1'b1;
                    n_state      = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                o_cmd.wr_en = 1'b1;
                if (i_st.gt) begin
                    o_cmd.j_dec = 1'b1;
                    n_state     = S_INS_RD;
                end else begin
                    o_cmd.wr_val  = 1'b1;
                    o_cmd.mark    = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_rsp         = sli_pkg::ST_OK;
                    n_state       = S_RESP;
                end
            end
            S_RM_RD: begin
                n_state = S_RM_CHK;
            end
            S_RM_CHK: begin
                // after the match, each later entry moves down one place
                if (i_st.found) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_jm1 = 1'b1;
                end else if (i_st.eq) begin
                    o_cmd.mark = 1'b1;
                end
                if (i_st.j_last) begin
                    o_cmd.cnt_dec = found_now;
                    n_rsp   = found_now ? sli_pkg::ST_OK : sli_pkg::ST_ABSENT;
                    n_state = S_RESP;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state     = S_RM_RD;
                end
            end
            S_DUMP_RD: begin
                n_state = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_data   = 1'b1;
                    o_cmd.out_status = sli_pkg::ST_OK;
                    if (i_st.j_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.j_inc = 1'b1;
                        n_state     = S_DUMP_RD;
                    end
                end
            end
            S_RESP: begin
                if (i_st.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_rsp;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> r_state == S_IDLE && i_in_valid)
        else $error("command taken outside idle");

    a_resp_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && i_st.out_free) |=> r_state == S_IDLE)
        else $error("response state stuck");

    a_one_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.cnt_inc && o_cmd.cnt_dec) && !(o_cmd.j_inc && o_cmd.j_dec))
        else $error("conflicting datapath commands");
`endif

endmodule

/* rtl/sorted_list_insert_remove.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_remove
// Sorted list of up to CAPACITY signed values with insert, remove and dump.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one command per beat (cmd, value). o_rsp returns results:
//   insert and remove give one result beat, dump gives one beat per stored
//   entry (last set on the final one) or a single empty error beat.
//   Commands are taken one at a time; i_req.ready is high only when idle.
//   How each command proceeds:
//     insert: descending scan, read then write per step
//     remove: full ascending scan, shifting after the match
//     dump:   ascending walk, a read then a result beat per entry
//     errors: no scan, straight to the result beat
//   Entries sit in a single-port-write, registered-read memory, so each
//   scan step reads an entry before it checks it.
//   The result register decouples the sides: a new command can be taken
//   while the previous result still waits. A stall on o_rsp holds the
//   sequencer at its next result and the result beat stays stable.
//   Reset empties the list and returns to idle; stored entries keep stale
//   contents that are never read.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sli_req_if.sink   i_req,
    sli_rsp_if.source o_rsp
);

    sli_pkg::t_dp_cmd    dp_cmd;
    sli_pkg::t_dp_status dp_st;
    logic                in_ready;

    assign i_req.ready = in_ready;

    sli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_cmd   (i_req.cmd),
        .i_st       (dp_st),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    sli_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_value (i_req.value),
        .i_cmd      (dp_cmd),
        .o_st       (dp_st),
        .o_rsp      (o_rsp)
    );

endmodule
